/* hw/rtl/array_list_insert_delete_top_assert.svh */
// assertion macros shared by the list block
`ifndef ARRAY_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_TOP_ASSERT_SVH

// same-cycle implication
`define ALID_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ALID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/alid_pkg.sv */
package alid_pkg;

   localparam int DATA_W       = 32;
   localparam int FUNC_W       = 2;
   localparam int POS_W        = 4;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 5;
   localparam int CAPACITY_DEF = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_SORTED = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_BEYOND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_COUNT = 3'd1,
      IDX_POS   = 3'd2,
      IDX_DEC   = 3'd3,
      IDX_INC   = 3'd4
   } idx_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        set_status;
      status_type  status;
      idx_sel_type idx_sel;
      logic        mem_rd;
      logic        mem_wr;
      logic        wr_value;
      logic        count_inc;
      logic        count_dec;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic     req_valid;
      func_type func;
      logic     full;
      logic     pos_gt_count;
      logic     pos_ge_count;
      logic     idx_gt_pos;
      logic     del_more;
      logic     greater;
      logic     idx_zero;
      logic     out_free;
   } sts_type;

endpackage

/* hw/rtl/alid_if.sv */
interface alid_req_if import alid_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink (input valid, input func, input position, input value, output ready);
endinterface

interface alid_rsp_if import alid_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [COUNT_W-1:0]       item_count;
   logic [POS_W-1:0]         placed_at;
   logic signed [DATA_W-1:0] read_value;

   modport source (output valid, output status, output item_count, output placed_at,
                   output read_value, input ready);
   modport sink (input valid, input status, input item_count, input placed_at,
                 input read_value, output ready);
endinterface

/* hw/rtl/alid_datapath.sv */
module alid_datapath import alid_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   alid_req_if.sink   req_if,
   alid_rsp_if.source rsp_if,
   input  cmd_type cmd,
   output sts_type sts
);

   localparam int AW = $clog2(CAPACITY);
   localparam int IW = $clog2(CAPACITY + 1);
   localparam int CW = (IW > POS_W) ? IW : POS_W;

   logic signed [DATA_W-1:0] entries_ff [CAPACITY];
   logic signed [DATA_W-1:0] rdata_ff;

   func_type                 func_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [AW-1:0]            idx_ff, idx_in;
   logic [IW-1:0]            count_ff, count_in;
   status_type               status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic [POS_W-1:0]         rsp_placed_ff;
   logic signed [DATA_W-1:0] rsp_read_ff;

   logic                     req_fire;
   logic [AW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] wdata;
   logic [CW-1:0]            pos_ext, count_ext, idx_ext;
   logic                     placed_ok, read_ok;

   assign req_if.ready = cmd.req_ready;
   assign req_fire     = req_if.valid & cmd.req_ready;

   assign pos_ext   = CW'(pos_ff);
   assign count_ext = CW'(count_ff);
   assign idx_ext   = CW'(idx_ff);

   // status toward the controller
   always_comb begin
      sts.req_valid    = req_if.valid;
      sts.func         = func_ff;
      sts.full         = (count_ff >= IW'(CAPACITY));
      sts.pos_gt_count = (pos_ext > count_ext);
      sts.pos_ge_count = (pos_ext >= count_ext);
      sts.idx_gt_pos   = (idx_ext > pos_ext);
      sts.del_more     = ((IW'(idx_ff) + IW'(1)) < count_ff);
      sts.greater      = (rdata_ff > val_ff);
      sts.idx_zero     = (idx_ff == '0);
      sts.out_free     = ~rsp_valid_ff | rsp_if.ready;
   end

   // neighbor address for the shift: below for inserts, above for delete; a read uses the index itself
   always_comb begin
      case (func_ff)
         FUNC_DELETE: rd_addr = idx_ff + AW'(1);
         FUNC_READ:   rd_addr = idx_ff;
         default:     rd_addr = idx_ff - AW'(1);
      endcase
   end

   assign wdata = cmd.wr_value ? val_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         entries_ff[idx_ff] <= wdata;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= entries_ff[rd_addr];
      end
   end

   always_comb begin
      case (cmd.idx_sel)
         IDX_COUNT: idx_in = AW'(count_ff);
         IDX_POS:   idx_in = AW'(pos_ff);
         IDX_DEC:   idx_in = idx_ff - AW'(1);
         IDX_INC:   idx_in = idx_ff + AW'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + IW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - IW'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      if (req_fire) begin
         status_in = ST_DONE;
      end else if (cmd.set_status) begin
         status_in = cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= func_type'(req_if.func);
         pos_ff  <= req_if.position;
         val_ff  <= req_if.value;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // output register
   assign placed_ok = (status_ff == ST_DONE) &&
                      ((func_ff == FUNC_INSERT) || (func_ff == FUNC_SORTED));
   assign read_ok   = (status_ff == ST_DONE) && (func_ff == FUNC_READ);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_placed_ff <= placed_ok ? POS_W'(idx_ff) : '0;
         rsp_read_ff   <= read_ok ? rdata_ff : '0;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.item_count = rsp_count_ff;
   assign rsp_if.placed_at  = rsp_placed_ff;
   assign rsp_if.read_value = rsp_read_ff;

endmodule

/* hw/rtl/alid_ctrl.sv */
module alid_ctrl import alid_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_TEST   = 6'b000100,
      S_MOVE   = 6'b001000,
      S_READ   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd            = '0;
      cmd.status     = ST_DONE;
      cmd.idx_sel    = IDX_HOLD;
      state_in       = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = ~reset;
            if (sts.req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (sts.func)
               FUNC_INSERT: begin
                  if (sts.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_FINISH;
                  end else if (sts.pos_gt_count) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BEYOND;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.idx_sel = IDX_COUNT;
                     state_in    = S_TEST;
                  end
               end
               FUNC_DELETE: begin
                  if (sts.pos_ge_count) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BEYOND;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.idx_sel = IDX_POS;
                     state_in    = S_TEST;
                  end
               end
               FUNC_SORTED: begin
                  if (sts.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.idx_sel = IDX_COUNT;
                     state_in    = S_TEST;
                  end
               end
               FUNC_READ: begin
                  if (sts.pos_ge_count) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BEYOND;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.idx_sel = IDX_POS;
                     state_in    = S_READ;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         // decide whether another entry has to move
         S_TEST: begin
            case (sts.func)
               FUNC_INSERT: begin
                  if (sts.idx_gt_pos) begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_MOVE;
                  end else begin
                     cmd.mem_wr    = 1'b1;
                     cmd.wr_value  = 1'b1;
                     cmd.count_inc = 1'b1;
                     state_in      = S_FINISH;
                  end
               end
               FUNC_DELETE: begin
                  if (sts.del_more) begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_MOVE;
                  end else begin
                     cmd.count_dec = 1'b1;
                     state_in      = S_FINISH;
                  end
               end
               FUNC_SORTED: begin
                  if (!sts.idx_zero) begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_MOVE;
                  end else begin
                     cmd.mem_wr    = 1'b1;
                     cmd.wr_value  = 1'b1;
                     cmd.count_inc = 1'b1;
                     state_in      = S_FINISH;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_MOVE: begin
            if ((sts.func == FUNC_SORTED) && !sts.greater) begin
               // gap found: drop the new value in
               cmd.mem_wr    = 1'b1;
               cmd.wr_value  = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.mem_wr  = 1'b1;
               cmd.idx_sel = (sts.func == FUNC_DELETE) ? IDX_INC : IDX_DEC;
               state_in    = S_TEST;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/array_list_insert_delete_top.sv */
// after acceptance: a check state, then for an insert or delete a test state and, per moved
// entry, a memory read and a write, or for a read a read state; a rejected request goes
// straight to the finish state, which loads the output register once it is free; a sorted
// insert stops moving entries at a gap or at index 0. A new request is taken only after the
// last result is loaded; a result may wait in the output register while the next is taken
// reset: synchronous, clears count, sequencer and result valid; entries are not cleared
`include "array_list_insert_delete_top_assert.svh"

module array_list_insert_delete_top import alid_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   alid_req_if.sink   req_if,
   alid_rsp_if.source rsp_if
);

   cmd_type cmd;
   sts_type sts;
   logic    req_take;
   logic    rsp_free;

   alid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   alid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (cmd),
      .sts    (sts)
   );

   assign req_take = req_if.valid & req_if.ready;
   assign rsp_free = !rsp_if.valid || rsp_if.ready;

   `ALID_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_take, !req_if.ready, "transaction overlap")
   `ALID_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.out_load, rsp_free, "result overwritten")
   `ALID_ASSERT_IMPLY(a_no_overflow, clock, reset, cmd.count_inc, !sts.full, "count past capacity")

endmodule
